[hw/rtl/glg_pkg.sv]
// ============================================================================
// glg_pkg - GPU load-level governor package
// Shared field widths, codes, config/item types and reset values.
// ============================================================================
package glg_pkg;

	// Default elaboration values for the top-level parameters
	localparam int MAX_LEVELS_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;

	// Fixed field widths
	localparam int ACTION_W = 2;
	localparam int SAMPLE_W = 32;
	localparam int LEVEL_W  = 4;
	localparam int RAMP_W   = 16;
	localparam int LAZY_W   = 8;
	localparam int CNT_W    = 5;
	localparam int STEP_W   = 3;
	localparam int TLIM_W   = 20;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 20;

	// Input action codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_SLEEP  = 2'd1,
		ACT_WAKE   = 2'd2
	} glg_action_e;

	// Config register indexes
	typedef enum logic [CFG_AW-1:0] {
		REG_GOVERNOR_MODE   = 3'd0,
		REG_RAMP_THRESHOLD  = 3'd1,
		REG_LAZINESS_RELOAD = 3'd2,
		REG_LEVEL_COUNT     = 3'd3,
		REG_DOWN_STEP       = 3'd4,
		REG_FLOOR_TIME      = 3'd5,
		REG_CEILING_TIME    = 3'd6,
		REG_DEFAULT_LEVEL   = 3'd7
	} glg_reg_e;

	typedef struct packed {
		logic                governor_mode;
		logic [RAMP_W-1:0]   ramp_threshold;
		logic [LAZY_W-1:0]   laziness_reload;
		logic [CNT_W-1:0]    level_count;
		logic [STEP_W-1:0]   down_step;
		logic [TLIM_W-1:0]   floor_time;
		logic [TLIM_W-1:0]   ceiling_time;
		logic [LEVEL_W-1:0]  default_level;
	} glg_cfg_t;

	localparam glg_cfg_t CFG_RESET = '{
		governor_mode:   1'b1,
		ramp_threshold:  16'd6000,
		laziness_reload: 8'd5,
		level_count:     5'd8,
		down_step:       3'd1,
		floor_time:      20'd5000,
		ceiling_time:    20'd50000,
		default_level:   4'd0
	};

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [SAMPLE_W-1:0] sample_total;
		logic [SAMPLE_W-1:0] sample_busy;
		logic [LEVEL_W-1:0]  current_level;
		logic                was_napping;
	} glg_item_t;

	// Outcome of the bin update for the item in flight
	typedef struct packed {
		logic decide;       // floor reached on a nonzero sample
		logic turbo;        // busy bin above ceiling
		logic busy_period;  // idle time below ramp threshold
	} glg_bin_flags_t;

endpackage

[hw/rtl/glg_bins.sv]
// ============================================================================
// glg_bins - saturating busy/total time bins
// Accumulates samples, raises the decision flags and clears on a decision or a sleep.
// ============================================================================
module glg_bins #(
	parameter int TIME_BITS = glg_pkg::TIME_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  glg_pkg::glg_item_t      item,
	input  glg_pkg::glg_cfg_t       cfg,
	output glg_pkg::glg_bin_flags_t flags
);
	import glg_pkg::*;

	localparam int SW = ((TIME_BITS > SAMPLE_W) ? TIME_BITS : SAMPLE_W) + 1;
	localparam int CW = (TIME_BITS > TLIM_W) ? TIME_BITS : TLIM_W;

	logic [TIME_BITS-1:0] total_q, busy_q;
	logic [TIME_BITS-1:0] total_sat, busy_sat, idle;
	logic [SW-1:0]        total_sum, busy_sum;
	logic                 sample_en, clear;

	assign sample_en = (item.action == ACT_SAMPLE) && cfg.governor_mode;
	assign clear     = (item.action == ACT_SLEEP);

	assign total_sum = SW'(total_q) + SW'(item.sample_total);
	assign busy_sum  = SW'(busy_q) + SW'(item.sample_busy);

	// Anything above the bin width saturates to all ones
	assign total_sat = (|total_sum[SW-1:TIME_BITS]) ? '1 : total_sum[TIME_BITS-1:0];
	assign busy_sat  = (|busy_sum[SW-1:TIME_BITS]) ? '1 : busy_sum[TIME_BITS-1:0];

	assign idle = (total_sat > busy_sat) ? (total_sat - busy_sat) : '0;

	always_comb begin
		flags.decide      = sample_en && (item.sample_total != '0)
			&& (CW'(total_sat) >= CW'(cfg.floor_time));
		flags.turbo       = CW'(busy_sat) > CW'(cfg.ceiling_time);
		flags.busy_period = CW'(idle) < CW'(cfg.ramp_threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			busy_q  <= '0;
		end else if (advance) begin
			if (clear || flags.decide) begin
				total_q <= '0;
				busy_q  <= '0;
			end else if (sample_en) begin
				total_q <= total_sat;
				busy_q  <= busy_sat;
			end
		end
	end

endmodule

[hw/rtl/glg_level.sv]
// ============================================================================
// glg_level - level decision
// Turbo, step up/down with laziness countdown, wake level, clamping.
// ============================================================================
module glg_level #(
	parameter int MAX_LEVELS = glg_pkg::MAX_LEVELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  glg_pkg::glg_item_t           item,
	input  glg_pkg::glg_bin_flags_t      flags,
	input  glg_pkg::glg_cfg_t            cfg,
	output logic                         change_valid,
	output logic [glg_pkg::LEVEL_W-1:0]  new_level
);
	import glg_pkg::*;

	localparam int NW = $clog2(MAX_LEVELS + 1);
	localparam int LW = ((NW > CNT_W) ? NW : CNT_W) + 1;

	logic [LW-1:0]     count, last, cur, up_sum, up_lv, dflt, lv;
	logic [LAZY_W-1:0] laz_q, laz_d;
	logic              busy_ok, idle_ok;

	always_comb begin
		if (cfg.level_count == '0)
			count = LW'(1);
		else if (LW'(cfg.level_count) > LW'(MAX_LEVELS))
			count = LW'(MAX_LEVELS);
		else
			count = LW'(cfg.level_count);
	end

	assign last    = count - LW'(1);
	assign cur     = LW'(item.current_level);
	assign busy_ok = (cur != '0) && (cur <= last);
	assign idle_ok = cur < last;
	assign up_sum  = cur + LW'(cfg.down_step);
	assign up_lv   = (up_sum > last) ? last : up_sum;
	assign dflt    = (LW'(cfg.default_level) > last) ? last : LW'(cfg.default_level);

	always_comb begin
		change_valid = 1'b0;
		lv           = '0;
		laz_d        = laz_q;
		case (item.action)
			ACT_SAMPLE: begin
				if (flags.decide) begin
					if (flags.turbo) begin
						change_valid = 1'b1;
					end else if (flags.busy_period) begin
						if (busy_ok) begin
							change_valid = 1'b1;
							lv           = cur - LW'(1);
						end
					end else if (idle_ok) begin
						if (laz_q != '0) begin
							laz_d = laz_q - LAZY_W'(1);
						end else begin
							laz_d = cfg.laziness_reload;
							if (cfg.down_step != '0) begin
								change_valid = 1'b1;
								lv           = up_lv;
							end
						end
					end
				end
			end
			ACT_WAKE: begin
				if (!item.was_napping && cfg.governor_mode) begin
					change_valid = 1'b1;
					lv           = dflt;
				end
			end
			default: ;
		endcase
	end

	assign new_level = lv[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			laz_q <= '0;
		else if (advance)
			laz_q <= laz_d;
	end

endmodule

[hw/rtl/gpu_load_level_governor.sv]
// ============================================================================
// gpu_load_level_governor - GPU performance level governor
// Turns busy/total time samples into power level change requests.
// ============================================================================
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------
//  s_*     | in  | s_tvalid / s_tready | tuser: action; tdata: samples,
//          |     |                     |   current level, nap flag
//  m_*     | out | m_tvalid / m_tready | tuser: change_valid; tdata: level
//  cfg_*   | in  | cfg_we              | cfg_addr selects, cfg_wdata value
//
//  An input transaction is captured in the input register, then the decision
//  logic feeds the result register. Throughput is one transaction per cycle
//  while the result side is not stalled; the only loop is the bin and
//  laziness state, updated as each item moves into the result register.
//  Reset clears the bins, the laziness count, both valid flags and loads
//  the config registers with their defaults.
//  A stalled result holds; the input side keeps taking one more item into
//  the input register while the result waits.
// ============================================================================
module gpu_load_level_governor #(
	parameter int MAX_LEVELS = glg_pkg::MAX_LEVELS_DEF,
	parameter int TIME_BITS  = glg_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [31:0] sample_total, [63:32] sample_busy, [67:64] current_level,
	// [68] was_napping, [71:69] zero
	input  logic [71:0]                s_tdata,
	// [1:0] action
	input  logic [glg_pkg::ACTION_W-1:0] s_tuser,
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [3:0] new_level, [7:4] zero
	output logic [7:0]                 m_tdata,
	// [0] change_valid
	output logic                       m_tuser,
	// config write port
	input  logic                       cfg_we,
	input  logic [glg_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [glg_pkg::CFG_DW-1:0] cfg_wdata
);
	import glg_pkg::*;

	glg_cfg_t       cfg_q;
	glg_item_t      item_in, item_s1;
	glg_bin_flags_t flags;
	logic           valid_s1, valid_s2, change_s2;
	logic [LEVEL_W-1:0] level_s2;
	logic           change_c;
	logic [LEVEL_W-1:0] level_c;
	logic           advance, in_xact;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (glg_reg_e'(cfg_addr))
				REG_GOVERNOR_MODE:   cfg_q.governor_mode   <= cfg_wdata[0];
				REG_RAMP_THRESHOLD:  cfg_q.ramp_threshold  <= cfg_wdata[RAMP_W-1:0];
				REG_LAZINESS_RELOAD: cfg_q.laziness_reload <= cfg_wdata[LAZY_W-1:0];
				REG_LEVEL_COUNT:     cfg_q.level_count     <= cfg_wdata[CNT_W-1:0];
				REG_DOWN_STEP:       cfg_q.down_step       <= cfg_wdata[STEP_W-1:0];
				REG_FLOOR_TIME:      cfg_q.floor_time      <= cfg_wdata[TLIM_W-1:0];
				REG_CEILING_TIME:    cfg_q.ceiling_time    <= cfg_wdata[TLIM_W-1:0];
				REG_DEFAULT_LEVEL:   cfg_q.default_level   <= cfg_wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ handshake
	// The input register moves on whenever the result register is empty or
	// being drained in this cycle; that move also commits the state update.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_xact  = s_tvalid && s_tready;

	always_comb begin
		item_in.action        = s_tuser;
		item_in.sample_total  = s_tdata[31:0];
		item_in.sample_busy   = s_tdata[63:32];
		item_in.current_level = s_tdata[67:64];
		item_in.was_napping   = s_tdata[68];
	end

	// ------------------------------------------------------- input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_xact)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_xact)
			item_s1 <= item_in;
	end

	// ----------------------------------------------------------- datapath
	// Bins: saturating adds plus floor / ceiling / ramp compares.
	glg_bins #(
		.TIME_BITS(TIME_BITS)
	) u_bins (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.flags   (flags)
	);

	// Level: turbo, up/down step with laziness, wake level, clamp.
	glg_level #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_level (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.flags        (flags),
		.cfg          (cfg_q),
		.change_valid (change_c),
		.new_level    (level_c)
	);

	// ------------------------------------------------------ result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			change_s2 <= change_c;
			level_s2  <= level_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = change_s2;
	assign m_tdata  = {4'b0000, level_s2};

endmodule

[hw/rtl/glg_checker.sv]
// ============================================================================
// glg_checker - port-level checks for the GPU load-level governor
// Watches the top-level handshakes and result payload; bound to the top.
// ============================================================================
module glg_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Input side only backs up when the result register is full and stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

	// A fresh result traces back to an input transaction through the input and result registers
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching input transaction");

	// No change requested means a zero level field
	a_zero_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 8'h00)
		else $error("level field set without a change request");

endmodule

bind gpu_load_level_governor glg_port_checks u_glg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[bench/glg_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// glg_checker - level request checker for the load-level governor
// Follows config writes and input transactions, predicts each level request
// and compares it with the result stream in order.
// ============================================================================
module glg_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [71:0]                  s_tdata,
	input  logic [glg_pkg::ACTION_W-1:0] s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [7:0]                   m_tdata,
	input  logic                         m_tuser,
	input  logic                         cfg_we,
	input  logic [glg_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [glg_pkg::CFG_DW-1:0]   cfg_wdata,
	output int                           errors,
	output int                           pending
);
	import glg_pkg::*;

	localparam int NLEV = MAX_LEVELS_DEF;
	localparam int TW   = TIME_BITS_DEF;

	typedef struct packed {
		logic               change;
		logic [LEVEL_W-1:0] level;
	} level_req_t;

	glg_cfg_t          regs;
	logic [TW-1:0]     total_bin;
	logic [TW-1:0]     busy_bin;
	logic [LAZY_W-1:0] lazy_left;
	level_req_t        expected_requests[$];
	level_req_t        oldest;
	int                mismatch_count = 0;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("%0t: level request mismatch: %s", $time, what);
	endtask

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TW] ? '1 : sum[TW-1:0];
	endfunction

	function automatic int clamp_level(input int lv, input int n);
		if (lv < 0)
			return 0;
		if (lv > n - 1)
			return n - 1;
		return lv;
	endfunction

	// Applies one input transaction to the bins and laziness count.
	function automatic level_req_t predict_request(input logic [ACTION_W-1:0] act,
			input logic [SAMPLE_W-1:0] s_total, input logic [SAMPLE_W-1:0] s_busy,
			input logic [LEVEL_W-1:0] cur, input logic nap);
		level_req_t    req;
		int            n;
		int            step;
		logic [TW-1:0] idle;
		req = '0;
		n = int'(regs.level_count);
		if (n < 1)
			n = 1;
		if (n > NLEV)
			n = NLEV;
		case (act)
			ACT_SAMPLE: begin
				if (regs.governor_mode) begin
					total_bin = sat_add(total_bin, TW'(s_total));
					busy_bin  = sat_add(busy_bin, TW'(s_busy));
					if (s_total != '0 && total_bin >= TW'(regs.floor_time)) begin
						if (busy_bin > TW'(regs.ceiling_time)) begin
							req.change = 1'b1;
							req.level  = '0;
						end else begin
							idle = (total_bin > busy_bin) ? total_bin - busy_bin : '0;
							step = 0;
							if (idle < TW'(regs.ramp_threshold)) begin
								if (cur > 0 && int'(cur) <= n - 1)
									step = -1;
							end else if (int'(cur) < n - 1) begin
								// countdown first; at zero, reload and take the down step
								if (lazy_left != '0) begin
									lazy_left = lazy_left - 1'b1;
								end else begin
									lazy_left = regs.laziness_reload;
									step = int'(regs.down_step);
								end
							end
							if (step != 0) begin
								req.change = 1'b1;
								req.level  = LEVEL_W'(clamp_level(int'(cur) + step, n));
							end
						end
						total_bin = '0;
						busy_bin  = '0;
					end
				end
			end
			ACT_SLEEP: begin
				total_bin = '0;
				busy_bin  = '0;
			end
			ACT_WAKE: begin
				if (!nap && regs.governor_mode) begin
					req.change = 1'b1;
					req.level  = LEVEL_W'(clamp_level(int'(regs.default_level), n));
				end
			end
			default: ;
		endcase
		return req;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs      = CFG_RESET;
			total_bin = '0;
			busy_bin  = '0;
			lazy_left = '0;
			expected_requests.delete();
			pending <= 0;
			errors  <= mismatch_count;
		end else begin
			if (cfg_we) begin
				case (glg_reg_e'(cfg_addr))
					REG_GOVERNOR_MODE:   regs.governor_mode   = cfg_wdata[0];
					REG_RAMP_THRESHOLD:  regs.ramp_threshold  = cfg_wdata[RAMP_W-1:0];
					REG_LAZINESS_RELOAD: regs.laziness_reload = cfg_wdata[LAZY_W-1:0];
					REG_LEVEL_COUNT:     regs.level_count     = cfg_wdata[CNT_W-1:0];
					REG_DOWN_STEP:       regs.down_step       = cfg_wdata[STEP_W-1:0];
					REG_FLOOR_TIME:      regs.floor_time      = cfg_wdata[TLIM_W-1:0];
					REG_CEILING_TIME:    regs.ceiling_time    = cfg_wdata[TLIM_W-1:0];
					REG_DEFAULT_LEVEL:   regs.default_level   = cfg_wdata[LEVEL_W-1:0];
					default: ;
				endcase
			end
			// results leave before this edge's input is predicted
			if (m_tvalid && m_tready) begin
				if (expected_requests.size() == 0) begin
					report_mismatch($sformatf("unexpected result tuser=%b tdata=%h",
						m_tuser, m_tdata));
				end else begin
					oldest = expected_requests.pop_front();
					if (m_tuser !== oldest.change)
						report_mismatch($sformatf("change_valid %b, want %b",
							m_tuser, oldest.change));
					if (m_tdata !== {4'b0000, oldest.level})
						report_mismatch($sformatf("tdata %h, want level %0d",
							m_tdata, oldest.level));
				end
			end
			if (s_tvalid && s_tready)
				expected_requests.push_back(predict_request(s_tuser, s_tdata[31:0],
					s_tdata[63:32], s_tdata[67:64], s_tdata[68]));
			pending <= expected_requests.size();
			errors  <= mismatch_count;
		end
	end

endmodule

[bench/tb_gpu_load_level_governor.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_gpu_load_level_governor - testbench for the GPU load-level governor
// Directed corner transactions, then phases of random samples under
// different register settings, with random stalls on both streams.
// ============================================================================
module tb_gpu_load_level_governor;
	import glg_pkg::*;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int CYCLE_LIMIT     = 400000;
	// action code the block must ignore
	localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = '1;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [71:0]         s_tdata   = '0;
	logic [ACTION_W-1:0] s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [7:0]          m_tdata;
	logic                m_tuser;
	logic                cfg_we    = 1'b0;
	logic [CFG_AW-1:0]   cfg_addr  = '0;
	logic [CFG_DW-1:0]   cfg_wdata = '0;

	int       mismatches;
	int       in_flight;
	int       cycle_count = 0;
	int       stall_left  = 0;
	bit       steady      = 1'b0;   // no idling on either side
	glg_cfg_t cfg_now     = CFG_RESET;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gpu_load_level_governor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	glg_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.errors   (mismatches),
		.pending  (in_flight)
	);

	// Hard stop in case a handshake never completes.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_gpu_load_level_governor failed");
			$finish;
		end
	end

	// Mostly short pauses, now and then a long one.
	function automatic int pick_pause();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] minus_or_zero(input logic [SAMPLE_W-1:0] a,
			input int unsigned b);
		return (a > b) ? a - b : '0;
	endfunction

	// Result side: tready drops for random stretches; always high for at
	// least one cycle between stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (!steady && $urandom_range(0, 99) < 25)
				stall_left <= pick_pause();
		end
	end

	// One input transaction. tvalid stays high across back-to-back items.
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] total,
			input logic [SAMPLE_W-1:0] busy, input logic [LEVEL_W-1:0] cur, input logic nap);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 30)
			gap = pick_pause();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, nap, cur, busy, total};
		do @(posedge clk); while (!s_tready);
	endtask

	// Wait until every request has come back.
	// The first edge lets the checker see the last accepted transaction.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input glg_reg_e idx, input logic [CFG_DW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Registers only change with the block idle.
	task automatic load_config(input glg_cfg_t c);
		drain();
		write_reg(REG_GOVERNOR_MODE,   CFG_DW'(c.governor_mode));
		write_reg(REG_RAMP_THRESHOLD,  CFG_DW'(c.ramp_threshold));
		write_reg(REG_LAZINESS_RELOAD, CFG_DW'(c.laziness_reload));
		write_reg(REG_LEVEL_COUNT,     CFG_DW'(c.level_count));
		write_reg(REG_DOWN_STEP,       CFG_DW'(c.down_step));
		write_reg(REG_FLOOR_TIME,      CFG_DW'(c.floor_time));
		write_reg(REG_CEILING_TIME,    CFG_DW'(c.ceiling_time));
		write_reg(REG_DEFAULT_LEVEL,   CFG_DW'(c.default_level));
		cfg_we  <= 1'b0;
		cfg_now  = c;
	endtask

	// Mostly load-following, small laziness so step-downs show up often.
	function automatic glg_cfg_t random_config();
		glg_cfg_t c;
		c.governor_mode = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 3))
			0:       c.ramp_threshold = '0;
			1:       c.ramp_threshold = '1;
			default: c.ramp_threshold = RAMP_W'($urandom_range(0, 20000));
		endcase
		if ($urandom_range(0, 9) < 8)
			c.laziness_reload = LAZY_W'($urandom_range(0, 3));
		else
			c.laziness_reload = LAZY_W'($urandom_range(0, 255));
		if ($urandom_range(0, 9) < 8)
			c.level_count = CNT_W'($urandom_range(1, 16));
		else
			c.level_count = CNT_W'($urandom_range(0, 31));
		c.down_step = STEP_W'($urandom_range(0, 7));
		case ($urandom_range(0, 5))
			0:       c.floor_time = '0;
			1:       c.floor_time = '1;
			default: c.floor_time = TLIM_W'($urandom_range(1, 20000));
		endcase
		case ($urandom_range(0, 5))
			0:       c.ceiling_time = '0;
			1:       c.ceiling_time = '1;
			default: c.ceiling_time = TLIM_W'($urandom_range(0, 100000));
		endcase
		c.default_level = LEVEL_W'($urandom_range(0, 15));
		return c;
	endfunction

	// Samples are shaped around the current floor, ceiling and ramp so that
	// decisions land on both sides of every threshold.
	task automatic send_random_item();
		logic [ACTION_W-1:0] act;
		logic [SAMPLE_W-1:0] total;
		logic [SAMPLE_W-1:0] busy;
		logic [LEVEL_W-1:0]  cur;
		int                  n;
		int                  pick;
		int unsigned         ramp;
		int unsigned         flr;
		n = int'(cfg_now.level_count);
		if (n < 1)
			n = 1;
		if (n > MAX_LEVELS_DEF)
			n = MAX_LEVELS_DEF;
		ramp = 32'(cfg_now.ramp_threshold);
		flr  = 32'(cfg_now.floor_time);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			act = ACT_SAMPLE;
		else if (pick < 80)
			act = ACT_SLEEP;
		else if (pick < 93)
			act = ACT_WAKE;
		else
			act = ACT_RESERVED;
		case ($urandom_range(0, 9))
			0:       total = '0;
			1, 2, 3: total = $urandom_range(0, flr / 2 + 1);   // accumulate
			8:       total = $urandom;
			9:       total = SAMPLE_MAX;
			default: total = $urandom_range(flr, flr + flr / 2 + 10);
		endcase
		case ($urandom_range(0, 7))
			0:       busy = '0;
			1, 2:    busy = minus_or_zero(total, $urandom_range(0, ramp));
			3, 4:    busy = minus_or_zero(total, ramp + $urandom_range(0, ramp + 100));
			5:       busy = cfg_now.ceiling_time + $urandom_range(1, 1000);
			6:       busy = $urandom;
			default: busy = SAMPLE_MAX;
		endcase
		if ($urandom_range(0, 99) < 80)
			cur = LEVEL_W'($urandom_range(0, n - 1));
		else
			cur = LEVEL_W'($urandom_range(0, 15));
		send_item(act, total, busy, cur, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		glg_cfg_t phase_cfg;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: 8 levels, floor 5000, ceiling 50000,
		// ramp 6000, laziness 5, step 1, default level 0.
		send_item(ACT_WAKE, 0, 0, 4'd3, 1'b0);                 // wake -> default
		send_item(ACT_WAKE, 0, 0, 4'd3, 1'b1);                 // napping -> nothing
		send_item(ACT_SAMPLE, 0, 0, 4'd0, 1'b0);               // zero sample
		send_item(ACT_SAMPLE, 0, SAMPLE_MAX, 4'd5, 1'b1);      // busy bin fills
		send_item(ACT_SAMPLE, 0, SAMPLE_MAX, 4'd5, 1'b0);      // busy bin saturates
		send_item(ACT_SAMPLE, SAMPLE_MAX, 0, 4'd5, 1'b0);      // turbo
		send_item(ACT_SAMPLE, 10000, 9000, 4'd3, 1'b0);        // busy -> step faster
		send_item(ACT_SAMPLE, 10000, 9000, 4'd0, 1'b0);        // already fastest
		send_item(ACT_SAMPLE, 20000, 0, 4'd3, 1'b0);           // idle -> step slower
		send_item(ACT_SAMPLE, 20000, 0, 4'd3, 1'b0);           // laziness countdown
		send_item(ACT_SAMPLE, 20000, 0, 4'd7, 1'b0);           // already slowest
		send_item(ACT_SAMPLE, 10000, 9500, 4'd12, 1'b0);       // level past the last
		send_item(ACT_SAMPLE, 20000, 0, 4'd15, 1'b1);
		send_item(ACT_SAMPLE, 3000, 0, 4'd2, 1'b0);            // below floor
		send_item(ACT_SLEEP, 0, 0, 4'd2, 1'b0);                // clears bins
		send_item(ACT_SAMPLE, 3000, 0, 4'd2, 1'b0);
		send_item(ACT_SAMPLE, SAMPLE_MAX, 5, 4'd2, 1'b0);      // total bin saturates
		send_item(ACT_RESERVED, SAMPLE_MAX, SAMPLE_MAX, 4'd15, 1'b1);
		send_item(ACT_SAMPLE, 50001, 50001, 4'd4, 1'b0);       // just above ceiling
		send_item(ACT_SAMPLE, 6000, 1, 4'd4, 1'b0);            // idle just below ramp
		send_item(ACT_SAMPLE, 6000, 0, 4'd4, 1'b0);            // idle equal to ramp

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					// all registers at their lowest
					phase_cfg = '0;
					phase_cfg.governor_mode = 1'b1;
				end
				1: phase_cfg = '1;   // all registers at their highest
				2: begin
					phase_cfg = random_config();
					phase_cfg.governor_mode = 1'b0;   // performance mode
				end
				3: begin
					// wake level clamped to the last level, big down steps
					phase_cfg = CFG_RESET;
					phase_cfg.laziness_reload = '0;
					phase_cfg.down_step       = 3'd4;
					phase_cfg.level_count     = 5'd6;
					phase_cfg.default_level   = 4'd15;
				end
				default: phase_cfg = random_config();
			endcase
			steady = (p % 3 == 1);
			load_config(phase_cfg);
			repeat (ITEMS_PER_PHASE) send_random_item();
		end

		drain();
		if (mismatches == 0 && in_flight == 0)
			$display("tb_gpu_load_level_governor passed");
		else
			$display("tb_gpu_load_level_governor failed");
		$finish;
	end

endmodule
